FILE: rtl/positional_list_store_core_defines.svh
// Assertion macros for the positional list store.
// Depends on: signals named clk and rst_n in the scope of each use.
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PLSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PLSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pls_pkg.sv
// Shared types and constants for the positional list store.
// No dependencies.
`timescale 1ns / 1ps

package pls_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    // compare width: holds position, count and count+1 without overflow
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_MODIFY = 2'd2,
        MODE_DUMP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OLD_RD,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PUT,
        S_DUMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [DATA_W-1:0]  item_value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  result_value;
        logic [POS_W-1:0]          entry_index;
        logic [POS_W-1:0]          entry_count;
        logic                      is_empty;
        logic                      last_of_run;
    } rsp_t;

    typedef struct packed {
        logic                      we;
        logic [ADDR_W-1:0]         waddr;
        logic [DATA_W-1:0]         wdata;
        logic                      re;
        logic [ADDR_W-1:0]         raddr;
    } ram_req_t;

    typedef struct packed {
        logic                      load;
        rsp_t                      word;
    } emit_t;

endpackage

FILE: rtl/pls_ram.sv
// Simple dual-port storage: one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module pls_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read enable
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pls_seq.sv
// Operation sequencer: decodes words, walks the store for shifts and dumps,
// and hands result words to the output register. Depends on pls_pkg.
`timescale 1ns / 1ps

module pls_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  pls_pkg::req_t          req,
    input  logic                   slot_free,
    output pls_pkg::emit_t         emit,
    output pls_pkg::ram_req_t      ram_req,
    input  logic [pls_pkg::DATA_W-1:0] rdata
);

    import pls_pkg::*;

    state_t              state_reg,  state_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    mode_t               mode_reg,   mode_next;
    logic [DATA_W-1:0]   value_reg,  value_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [ADDR_W-1:0]   idx_reg,    idx_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   old_reg,    old_next;

    logic [CMP_W-1:0]    cnt_w;
    logic [CMP_W-1:0]    req_pos_w;
    logic [CMP_W-1:0]    pos_w;
    logic [CMP_W-1:0]    idx_w;
    logic                dump_last;

    assign cnt_w     = CMP_W'(count_reg);
    assign req_pos_w = CMP_W'(req.position);
    assign pos_w     = CMP_W'(pos_reg);
    assign idx_w     = CMP_W'(idx_reg);
    assign dump_last = (idx_w + CMP_W'(1)) == cnt_w;
    assign req_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        old_reg    <= old_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        old_next    = old_reg;
        ram_req     = '0;
        emit        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next   = req.mode;
                    value_next  = req.item_value;
                    pos_next    = req.position;
                    status_next = ST_OK;
                    old_next    = '0;
                    state_next  = S_EMIT;
                    if (req.mode == MODE_INSERT)
                    begin
                        if (req_pos_w == '0 || req_pos_w > cnt_w + CMP_W'(1))
                        begin
                            status_next = ST_BADPOS;
                        end
                        else if (cnt_w == CMP_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (req_pos_w <= cnt_w)
                        begin
                            // move the tail up, starting from the last entry
                            ram_req.re    = 1'b1;
                            ram_req.raddr = ADDR_W'(cnt_w - CMP_W'(1));
                            idx_next      = ADDR_W'(count_reg);
                            state_next    = S_SHIFT_UP;
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        if (req.mode == MODE_DUMP)
                        begin
                            pos_next = '0;
                        end
                    end
                    else if (req.mode == MODE_DUMP)
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = '0;
                        idx_next      = '0;
                        state_next    = S_DUMP;
                    end
                    else if (req_pos_w == '0 || req_pos_w > cnt_w)
                    begin
                        status_next = ST_BADPOS;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_W'(req_pos_w - CMP_W'(1));
                        state_next    = S_OLD_RD;
                    end
                end
            end

            S_OLD_RD:
            begin
                old_next = rdata;
                if (mode_reg == MODE_MODIFY)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = ADDR_W'(pos_w - CMP_W'(1));
                    ram_req.wdata = value_reg;
                    state_next    = S_EMIT;
                end
                else if (pos_w < cnt_w)
                begin
                    // pull the tail down, starting just past the removed entry
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(pos_reg);
                    idx_next      = ADDR_W'(pos_w - CMP_W'(1));
                    state_next    = S_SHIFT_DN;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_SHIFT_UP:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = rdata;
                if (idx_w > pos_w)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(idx_w - CMP_W'(2));
                    idx_next      = idx_reg - ADDR_W'(1);
                end
                else
                begin
                    state_next = S_PUT;
                end
            end

            S_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = ADDR_W'(pos_w - CMP_W'(1));
                ram_req.wdata = value_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_EMIT;
            end

            S_SHIFT_DN:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg;
                ram_req.wdata = rdata;
                if (idx_w + CMP_W'(2) < cnt_w)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ADDR_W'(idx_w + CMP_W'(2));
                    idx_next      = idx_reg + ADDR_W'(1);
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_EMIT;
                end
            end

            S_DUMP:
            begin
                // read data holds while the output slot is busy
                if (slot_free)
                begin
                    emit.load              = 1'b1;
                    emit.word.status       = ST_OK;
                    emit.word.result_value = rdata;
                    emit.word.entry_index  = POS_W'(idx_w + CMP_W'(1));
                    emit.word.entry_count  = POS_W'(count_reg);
                    emit.word.is_empty     = (count_reg == '0);
                    emit.word.last_of_run  = dump_last;
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = ADDR_W'(idx_w + CMP_W'(1));
                        idx_next      = idx_reg + ADDR_W'(1);
                    end
                end
            end

            S_EMIT:
            begin
                if (slot_free)
                begin
                    emit.load              = 1'b1;
                    emit.word.status       = status_reg;
                    emit.word.result_value = old_reg;
                    emit.word.entry_index  = pos_reg;
                    emit.word.entry_count  = POS_W'(count_reg);
                    emit.word.is_empty     = (count_reg == '0);
                    emit.word.last_of_run  = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/positional_list_store_core.sv
// Insert shifts the tail up then writes the new entry, remove shifts it down;
// a dump emits one word per cycle, while the output register is free, after
// reading the first entry. One operation at a time:
// the next word is taken once the last result word is in the output register.
// Reset clears the entry count and control; store contents are not cleared.
`timescale 1ns / 1ps

module positional_list_store_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  pls_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output pls_pkg::rsp_t   rsp
);

    import pls_pkg::*;

    emit_t               emit;
    ram_req_t            ram_req;
    logic [DATA_W-1:0]   rdata;
    logic                slot_free;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    pls_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .slot_free (slot_free),
        .emit      (emit),
        .ram_req   (ram_req),
        .rdata     (rdata)
    );

    pls_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            rsp_reg <= emit.word;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/pls_checker.sv
// Port-level checks for positional_list_store_core, bound to the top level.
// Depends on pls_pkg and positional_list_store_core_defines.svh.
`timescale 1ns / 1ps
`include "positional_list_store_core_defines.svh"

module pls_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pls_pkg::rsp_t rsp
);

    import pls_pkg::*;

    `PLSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled word changed")
    `PLSC_ASSERT_NOW(a_empty_flag, rsp_valid, rsp.is_empty == (rsp.entry_count == '0), "empty flag disagrees with count")
    `PLSC_ASSERT_NOW(a_err_last, rsp_valid && rsp.status != ST_OK, rsp.last_of_run, "error word not marked last")
    `PLSC_ASSERT_NOW(a_run_busy, rsp_valid && !rsp.last_of_run, !req_ready, "new word taken during a dump")
    `PLSC_ASSERT_NEXT(a_one_at_time, req_valid && req_ready, !req_ready, "second word taken back to back")

endmodule

bind positional_list_store_core pls_checker u_pls_checker (.*);
